>>> rtl/counter_priority_task_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Assertion wrappers that vanish when the code is read for synthesis.
// ----------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CPTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CPTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CPTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CPTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/cpts_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Types, codes and constants shared by the scheduler files.
// ----------------------------------------------------------------------------
package cpts_pkg;

  localparam int ACT_W  = 3;
  localparam int TID_W  = 6;
  localparam int TASK_W = 6;
  localparam int PRIO_W = 8;
  localparam int DEP_W  = 8;
  localparam int CNT_W  = 16;
  localparam int STS_W  = 2;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
  localparam logic [DEP_W-1:0]        DEP_MAX = 8'hFF;
  localparam logic [PRIO_W-1:0]       INIT_PRIO_RST = 8'd1;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK        = 3'd0,
    ACT_YIELD       = 3'd1,
    ACT_FORK        = 3'd2,
    ACT_EXIT        = 3'd3,
    ACT_SET_PRIO    = 3'd4,
    ACT_PREEMPT_DIS = 3'd5,
    ACT_PREEMPT_EN  = 3'd6
  } action_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_NO_RUN = 2'd2,
    STS_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic init;
    logic accept;
    logic exec;
    logic pass_start;
    logic recharge;
    logic scan_step;
    logic commit;
    logic fail;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic resched;
    logic scan_last;
    logic best_pos;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/cpts_in_if.sv
// ----------------------------------------------------------------------------
// Scheduler input channel
// Valid/ready channel carrying one scheduler action.
// ----------------------------------------------------------------------------
interface cpts_in_if;
  logic                         valid;
  logic                         ready;
  logic [cpts_pkg::ACT_W-1:0]   action;
  logic [cpts_pkg::TID_W-1:0]   task_id;
  logic [cpts_pkg::PRIO_W-1:0]  new_priority;

  modport source (output valid, output action, output task_id, output new_priority,
                  input ready);
  modport sink (input valid, input action, input task_id, input new_priority,
                output ready);
endinterface

>>> rtl/cpts_out_if.sv
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying one scheduler result.
// ----------------------------------------------------------------------------
interface cpts_out_if;
  logic                         valid;
  logic                         ready;
  logic [cpts_pkg::TASK_W-1:0]  current_task;
  logic                         switched;
  logic [cpts_pkg::TASK_W-1:0]  created_task;
  logic [cpts_pkg::STS_W-1:0]   status;

  modport source (output valid, output current_task, output switched,
                  output created_task, output status, input ready);
  modport sink (input valid, input current_task, input switched,
                input created_task, input status, output ready);
endinterface

>>> rtl/cpts_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences each action, the scan and recharge passes and the result transfer.
// ----------------------------------------------------------------------------
`include "counter_priority_task_scheduler_unit_macros.svh"

module cpts_ctrl #(
  parameter int MAX_RECHARGE_PASSES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cpts_pkg::sts_t    sts,
  output cpts_pkg::cmd_t    cmd
);
  import cpts_pkg::*;

  localparam int PASS_W = $clog2(MAX_RECHARGE_PASSES + 1);
  localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(MAX_RECHARGE_PASSES);

  state_t            state_r, state_nxt;
  logic [PASS_W-1:0] pass_cnt_r, pass_cnt_nxt;
  logic              passes_out;

  assign passes_out = (pass_cnt_r == PASS_LAST);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:     state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_EXEC;
      S_EXEC:     state_nxt = sts.resched ? S_SCAN : S_DONE;
      S_SCAN:     if (sts.scan_last) state_nxt = S_SCAN_END;
      S_SCAN_END: state_nxt = S_DECIDE;
      S_DECIDE:   state_nxt = (sts.best_pos || passes_out) ? S_DONE : S_SCAN;
      S_DONE:     if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    pass_cnt_nxt = pass_cnt_r;
    unique case (state_r)
      S_INIT: cmd.init = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_EXEC: begin
        cmd.exec       = 1'b1;
        cmd.pass_start = sts.resched;
        pass_cnt_nxt   = '0;
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_DECIDE: begin
        if (sts.best_pos) begin
          cmd.commit = 1'b1;
        end else if (passes_out) begin
          cmd.fail = 1'b1;
        end else begin
          cmd.pass_start = 1'b1;
          cmd.recharge   = 1'b1;
          pass_cnt_nxt   = pass_cnt_r + 1'b1;
        end
      end
      S_DONE: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      pass_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      pass_cnt_r <= pass_cnt_nxt;
    end
  end

  `CPTS_ASSERT_NXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_r == S_EXEC, "accepted item not executed")
  `CPTS_ASSERT_IMP(a_pass_bound, clk, rst_n, state_r == S_SCAN, pass_cnt_r <= PASS_LAST, "recharge passes exceeded")
  `CPTS_ASSERT_IMP(a_decide_order, clk, rst_n, state_r == S_DECIDE, $past(state_r) == S_SCAN_END, "decision without finished scan")

endmodule

>>> rtl/cpts_dpath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Task table memories, action execution, scan and recharge, result register.
// ----------------------------------------------------------------------------
module cpts_dpath #(
  parameter int TASK_SLOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cpts_pkg::cmd_t               cmd,
  output cpts_pkg::sts_t               sts,
  input  logic [cpts_pkg::ACT_W-1:0]   in_action,
  input  logic [cpts_pkg::TID_W-1:0]   in_task_id,
  input  logic [cpts_pkg::PRIO_W-1:0]  in_new_priority,
  input  logic                         cfg_we,
  input  logic [cpts_pkg::PRIO_W-1:0]  cfg_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [cpts_pkg::TASK_W-1:0]  out_current_task,
  output logic                         out_switched,
  output logic [cpts_pkg::TASK_W-1:0]  out_created_task,
  output logic [cpts_pkg::STS_W-1:0]   out_status
);
  import cpts_pkg::*;

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int NFS_W = $clog2(TASK_SLOTS + 1);
  localparam int CMP_W = TID_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_SLOTS - 1);
  localparam logic [NFS_W-1:0] NFS_FULL = NFS_W'(TASK_SLOTS);

  logic [CNT_W-1:0]  cnt_mem  [TASK_SLOTS];
  logic [PRIO_W-1:0] prio_mem [TASK_SLOTS];
  logic [DEP_W-1:0]  dep_mem  [TASK_SLOTS];

  logic signed [CNT_W-1:0] cnt_q;
  logic [PRIO_W-1:0]       prio_q;
  logic [DEP_W-1:0]        dep_q;
  logic [IDX_W-1:0]        rd_addr;

  logic [TASK_SLOTS-1:0]   running_r;
  logic [IDX_W-1:0]        cur_r, before_r, created_r, pick_r;
  logic [IDX_W-1:0]        scan_idx_r, cmp_idx_r;
  logic [NFS_W-1:0]        nfs_r;
  action_t                 act_r;
  logic [TID_W-1:0]        tid_r;
  logic [PRIO_W-1:0]       nprio_r;
  status_t                 status_r;
  logic                    cmp_vld_r, rech_r;
  logic signed [CNT_W-1:0] best_r;

  logic                    out_valid_r;
  logic [TASK_W-1:0]       out_cur_r, out_created_r;
  logic                    out_sw_r;
  logic [STS_W-1:0]        out_sts_r;

  // Action execution against the current task's entry.
  logic signed [CNT_W-1:0] dec;
  logic                    ex_cnt_we, ex_prio_we, ex_dep_we, ex_resched, ex_fork, ex_clr_run;
  logic signed [CNT_W-1:0] ex_cnt_wd;
  logic [PRIO_W-1:0]       ex_prio_wd;
  logic [DEP_W-1:0]        ex_dep_wd;
  logic [IDX_W-1:0]        ex_addr;
  status_t                 ex_status;

  // Scan and recharge of one returned entry.
  logic signed [CNT_W-1:0] half;
  logic signed [CNT_W:0]   rch_sum;
  logic signed [CNT_W-1:0] rch_val, cand;
  logic                    cmp_valid_slot, take, rch_we;

  // Table write port.
  logic                    cnt_we, prio_we, dep_we;
  logic [IDX_W-1:0]        wr_addr;
  logic [CNT_W-1:0]        cnt_wd;
  logic [PRIO_W-1:0]       prio_wd;
  logic [DEP_W-1:0]        dep_wd;
  logic [PRIO_W-1:0]       init_val;

  assign rd_addr = cmd.accept ? cur_r : scan_idx_r;

  always_ff @(posedge clk) begin
    cnt_q  <= cnt_mem[rd_addr];
    prio_q <= prio_mem[rd_addr];
    dep_q  <= dep_mem[rd_addr];
    if (cnt_we)  cnt_mem[wr_addr]  <= cnt_wd;
    if (prio_we) prio_mem[wr_addr] <= prio_wd;
    if (dep_we)  dep_mem[wr_addr]  <= dep_wd;
  end

  assign dec = (cnt_q == CNT_MIN) ? cnt_q : cnt_q - 16'sd1;

  always_comb begin
    ex_cnt_we  = 1'b0;
    ex_prio_we = 1'b0;
    ex_dep_we  = 1'b0;
    ex_resched = 1'b0;
    ex_fork    = 1'b0;
    ex_clr_run = 1'b0;
    ex_cnt_wd  = '0;
    ex_prio_wd = prio_q;
    ex_dep_wd  = '0;
    ex_addr    = cur_r;
    ex_status  = STS_OK;
    unique case (act_r)
      ACT_TICK: begin
        ex_cnt_we = 1'b1;
        if (dec > 0 || dep_q != '0) begin
          ex_cnt_wd = dec;
        end else begin
          ex_resched = 1'b1;
        end
      end
      ACT_YIELD: begin
        ex_cnt_we  = 1'b1;
        ex_resched = 1'b1;
      end
      ACT_FORK: begin
        if (nfs_r >= NFS_FULL) begin
          ex_status = STS_FULL;
        end else begin
          ex_fork    = 1'b1;
          ex_addr    = nfs_r[IDX_W-1:0];
          ex_cnt_we  = 1'b1;
          ex_cnt_wd  = {{(CNT_W-PRIO_W){1'b0}}, prio_q};
          ex_prio_we = 1'b1;
          ex_dep_we  = 1'b1;
        end
      end
      ACT_EXIT: begin
        ex_cnt_we  = 1'b1;
        ex_clr_run = 1'b1;
        ex_resched = 1'b1;
      end
      ACT_SET_PRIO: begin
        if (CMP_W'(tid_r) < CMP_W'(nfs_r)) begin
          ex_prio_we = 1'b1;
          ex_prio_wd = nprio_r;
          ex_addr    = tid_r[IDX_W-1:0];
        end else begin
          ex_status = STS_EMPTY;
        end
      end
      ACT_PREEMPT_DIS: begin
        ex_dep_we = 1'b1;
        ex_dep_wd = (dep_q == DEP_MAX) ? dep_q : dep_q + 1'b1;
      end
      ACT_PREEMPT_EN: begin
        ex_dep_we = 1'b1;
        ex_dep_wd = (dep_q == '0) ? dep_q : dep_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign half    = cnt_q >>> 1;
  assign rch_sum = {half[CNT_W-1], half} + $signed({{(CNT_W-PRIO_W+1){1'b0}}, prio_q});
  assign rch_val = (rch_sum > $signed({1'b0, CNT_MAX})) ? CNT_MAX : rch_sum[CNT_W-1:0];
  assign cand    = rech_r ? rch_val : cnt_q;
  assign cmp_valid_slot = (NFS_W'(cmp_idx_r) < nfs_r);
  assign take    = cmp_vld_r && cmp_valid_slot && running_r[cmp_idx_r] && (cand > best_r);
  assign rch_we  = cmp_vld_r && rech_r && cmp_valid_slot;

  assign init_val = cfg_we ? cfg_data : INIT_PRIO_RST;

  always_comb begin
    cnt_we  = 1'b0;
    prio_we = 1'b0;
    dep_we  = 1'b0;
    wr_addr = cur_r;
    cnt_wd  = ex_cnt_wd;
    prio_wd = ex_prio_wd;
    dep_wd  = ex_dep_wd;
    priority if (cmd.init) begin
      cnt_we  = 1'b1;
      prio_we = 1'b1;
      dep_we  = 1'b1;
      wr_addr = '0;
      cnt_wd  = {{(CNT_W-PRIO_W){1'b0}}, init_val};
      prio_wd = init_val;
      dep_wd  = '0;
    end else if (cfg_we) begin
      cnt_we  = 1'b1;
      prio_we = 1'b1;
      wr_addr = '0;
      cnt_wd  = {{(CNT_W-PRIO_W){1'b0}}, cfg_data};
      prio_wd = cfg_data;
    end else if (cmd.exec) begin
      cnt_we  = ex_cnt_we;
      prio_we = ex_prio_we;
      dep_we  = ex_dep_we;
      wr_addr = ex_addr;
    end else if (rch_we) begin
      cnt_we  = 1'b1;
      wr_addr = cmp_idx_r;
      cnt_wd  = rch_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= TASK_SLOTS'(1);
      cur_r       <= '0;
      nfs_r       <= NFS_W'(1);
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_step;
      if (cmd.exec && ex_fork) begin
        running_r[nfs_r[IDX_W-1:0]] <= 1'b1;
        nfs_r <= nfs_r + 1'b1;
      end
      if (cmd.exec && ex_clr_run) running_r[cur_r] <= 1'b0;
      if (cmd.commit) cur_r <= pick_r;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r    <= action_t'(in_action);
      tid_r    <= in_task_id;
      nprio_r  <= in_new_priority;
      before_r <= cur_r;
    end
    if (cmd.exec) begin
      status_r  <= ex_status;
      created_r <= ex_fork ? nfs_r[IDX_W-1:0] : '0;
    end
    if (cmd.fail) status_r <= STS_NO_RUN;
    if (cmd.pass_start) begin
      scan_idx_r <= '0;
      best_r     <= '1;
      rech_r     <= cmd.recharge;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    cmp_idx_r <= scan_idx_r;
    if (take) begin
      best_r <= cand;
      pick_r <= cmp_idx_r;
    end
    if (cmd.load_out) begin
      out_cur_r     <= TASK_W'(cur_r);
      out_sw_r      <= (cur_r != before_r);
      out_created_r <= TASK_W'(created_r);
      out_sts_r     <= status_r;
    end
  end

  assign sts.resched   = ex_resched;
  assign sts.scan_last = (scan_idx_r == IDX_LAST);
  assign sts.best_pos  = (best_r > 0);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_current_task = out_cur_r;
  assign out_switched     = out_sw_r;
  assign out_created_task = out_created_r;
  assign out_status       = out_sts_r;

endmodule

>>> rtl/counter_priority_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Counter priority task scheduler
// Task table with time-slice counters and priorities, one result per action.
// ----------------------------------------------------------------------------
//   Port      Direction  Carries
//   in_ch     sink       action, task_id, new_priority
//   out_ch    source     current_task, switched, created_task, status
//   cfg_*     write      init_priority
//
// An action without a reschedule runs through EXEC and DONE to the result
// register. A reschedule adds a scan of all TASK_SLOTS entries, one table
// read per cycle, then S_SCAN_END and S_DECIDE; each recharge pass, at most
// MAX_RECHARGE_PASSES, repeats them. S_INIT loads slot zero before input opens.
// A stalled result holds the block until its transfer completes.
module counter_priority_task_scheduler_unit #(
  parameter int TASK_SLOTS          = 64,
  parameter int MAX_RECHARGE_PASSES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  cpts_in_if.sink                      in_ch,
  cpts_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [cpts_pkg::PRIO_W-1:0]  cfg_data
);
  import cpts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cpts_ctrl #(
    .MAX_RECHARGE_PASSES(MAX_RECHARGE_PASSES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cpts_dpath #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_ch.action),
    .in_task_id       (in_ch.task_id),
    .in_new_priority  (in_ch.new_priority),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_current_task (out_ch.current_task),
    .out_switched     (out_ch.switched),
    .out_created_task (out_ch.created_task),
    .out_status       (out_ch.status)
  );

endmodule

>>> tb/sv/tb_chan_if.sv
// ----------------------------------------------------------------------------
// Scheduler testbench channels
// Configuration signal bundle used by the scheduler testbench.
// ----------------------------------------------------------------------------
// The RTL interfaces cpts_in_if and cpts_out_if are used directly by the bench;
// this file holds a small bundle of the configuration signals.
interface tb_cfg_if;
  logic                        we;
  logic [cpts_pkg::PRIO_W-1:0] data;
endinterface

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Counter priority task scheduler testbench
// Drives scheduler actions through a directed table and random task-life
// sequences, predicts every result from an internal copy of the task table
// and checks each result transfer field by field under random stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpts_pkg::*;

  localparam int SLOTS  = 64;
  localparam int PASSES = 16;
  localparam int LAT    = 3 + (PASSES + 1) * (SLOTS + 2);
  localparam int WATCH  = 40 * LAT;
  localparam int N_RAND = 1000;

  typedef struct packed {
    logic [TASK_W-1:0] cur;
    logic              sw;
    logic [TASK_W-1:0] created;
    status_t           sts;
  } sched_result_t;

  typedef struct {
    action_t           act;
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
    bit                known;
    sched_result_t     res;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  cpts_in_if  in_ch();
  cpts_out_if out_ch();
  tb_cfg_if   cfg();

  counter_priority_task_scheduler_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg.we), .cfg_data(cfg.data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Task table copy.
  logic [PRIO_W-1:0]       t_init;
  bit                      t_valid [SLOTS];
  bit                      t_run [SLOTS];
  logic signed [CNT_W-1:0] t_cnt [SLOTS];
  logic [PRIO_W-1:0]       t_prio [SLOTS];
  logic [DEP_W-1:0]        t_dep [SLOTS];
  int                      t_cur;
  int                      t_next;

  sched_result_t pending_results[$];
  int  errors = 0;
  int  idle_cnt = 0;
  int  in_idle_pct = 0;
  int  out_stall_pct = 0;

  function automatic void table_reset();
    for (int i = 0; i < SLOTS; i++) begin
      t_valid[i] = 0;
      t_run[i] = 0;
      t_cnt[i] = '0;
      t_prio[i] = '0;
      t_dep[i] = '0;
    end
    t_init = INIT_PRIO_RST;
    t_valid[0] = 1;
    t_run[0] = 1;
    t_cnt[0] = t_init;
    t_prio[0] = t_init;
    t_cur = 0;
    t_next = 1;
  endfunction

  function automatic bit pick_runnable();
    int best;
    int pick;
    int v;
    for (int pass = 0; ; pass++) begin
      best = -1;
      pick = 0;
      for (int i = 0; i < SLOTS; i++)
        if (t_valid[i] && t_run[i] && int'(t_cnt[i]) > best) begin
          best = t_cnt[i];
          pick = i;
        end
      if (best > 0) begin
        t_cur = pick;
        return 1;
      end
      if (pass >= PASSES) return 0;
      for (int i = 0; i < SLOTS; i++)
        if (t_valid[i]) begin
          v = (int'(t_cnt[i]) >>> 1) + int'(t_prio[i]);
          t_cnt[i] = (v > 32767) ? CNT_MAX : v[CNT_W-1:0];
        end
    end
  endfunction

  function automatic sched_result_t predict_step(action_t act, int tid,
                                                 logic [PRIO_W-1:0] prio);
    sched_result_t r;
    int  was;
    bit  resched;
    was = t_cur;
    resched = 0;
    r.created = '0;
    r.sts = STS_OK;
    case (act)
      ACT_TICK: begin
        if (t_cnt[t_cur] != CNT_MIN) t_cnt[t_cur] = t_cnt[t_cur] - 1;
        if (!(t_cnt[t_cur] > 0 || t_dep[t_cur] != 0)) begin
          t_cnt[t_cur] = '0;
          resched = 1;
        end
      end
      ACT_YIELD: begin
        t_cnt[t_cur] = '0;
        resched = 1;
      end
      ACT_FORK: begin
        if (t_next >= SLOTS) r.sts = STS_FULL;
        else begin
          t_valid[t_next] = 1;
          t_run[t_next] = 1;
          t_prio[t_next] = t_prio[t_cur];
          t_cnt[t_next] = {8'd0, t_prio[t_cur]};
          t_dep[t_next] = '0;
          r.created = t_next[TASK_W-1:0];
          t_next++;
        end
      end
      ACT_EXIT: begin
        t_run[t_cur] = 0;
        t_cnt[t_cur] = '0;
        resched = 1;
      end
      ACT_SET_PRIO: begin
        if (!t_valid[tid]) r.sts = STS_EMPTY;
        else t_prio[tid] = prio;
      end
      ACT_PREEMPT_DIS: if (t_dep[t_cur] != DEP_MAX) t_dep[t_cur]++;
      ACT_PREEMPT_EN:  if (t_dep[t_cur] != 0) t_dep[t_cur]--;
      default: ;
    endcase
    if (resched && !pick_runnable()) r.sts = STS_NO_RUN;
    r.cur = t_cur[TASK_W-1:0];
    r.sw = (t_cur != was);
    return r;
  endfunction

  // Result side: random stalls, checking at the rising edge.
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > WATCH) begin
        $display("[FAIL] regression broken");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no expectation waiting");
          errors++;
        end else begin
          sched_result_t e;
          e = pending_results.pop_front();
          if (out_ch.current_task !== e.cur) begin
            $error("current_task expected %0d got %0d", e.cur, out_ch.current_task);
            errors++;
          end
          if (out_ch.switched !== e.sw) begin
            $error("switched expected %0d got %0d", e.sw, out_ch.switched);
            errors++;
          end
          if (out_ch.created_task !== e.created) begin
            $error("created_task expected %0d got %0d", e.created, out_ch.created_task);
            errors++;
          end
          if (out_ch.status !== e.sts) begin
            $error("status expected %0d got %0d", e.sts, out_ch.status);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_item(action_t act, logic [TID_W-1:0] tid, logic [PRIO_W-1:0] prio);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.task_id <= tid;
    in_ch.new_priority <= prio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_step(act, tid, prio));
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LAT + 8) @(negedge clk);
  endtask

  task automatic write_init(logic [PRIO_W-1:0] v);
    cfg.we <= 1'b1;
    cfg.data <= v;
    @(negedge clk);
    cfg.we <= 1'b0;
    t_init = v;
    t_prio[0] = v;
    t_cnt[0] = {8'd0, v};
  endtask

  function automatic action_t pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 40) return ACT_TICK;
    if (r < 50) return ACT_YIELD;
    if (r < 62) return ACT_FORK;
    if (r < 67) return ACT_EXIT;
    if (r < 80) return ACT_SET_PRIO;
    if (r < 90) return ACT_PREEMPT_DIS;
    return ACT_PREEMPT_EN;
  endfunction

  step_row_t directed[$];
  step_row_t row;
  logic [PRIO_W-1:0] p;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.task_id = '0;
    in_ch.new_priority = '0;
    cfg.we = 1'b0;
    cfg.data = '0;
    table_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed = '{
      '{ACT_TICK,        6'd0,  8'd0,   1, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_SET_PRIO,    6'd63, 8'd5,   1, '{6'd0, 1'b0, 6'd0, STS_EMPTY}},
      '{ACT_FORK,        6'd0,  8'd0,   1, '{6'd0, 1'b0, 6'd1, STS_OK}},
      '{ACT_SET_PRIO,    6'd1,  8'd255, 1, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_YIELD,       6'd0,  8'd0,   0, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_PREEMPT_DIS, 6'd0,  8'd0,   0, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_TICK,        6'd0,  8'd0,   0, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_PREEMPT_EN,  6'd0,  8'd0,   0, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_PREEMPT_EN,  6'd0,  8'd0,   0, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_SET_PRIO,    6'd0,  8'd0,   0, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_SET_PRIO,    6'd1,  8'd0,   0, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_EXIT,        6'd0,  8'd0,   0, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_EXIT,        6'd0,  8'd0,   0, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_TICK,        6'd0,  8'd0,   0, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{action_t'(3'd7), 6'd42, 8'd170, 0, '{6'd0, 1'b0, 6'd0, STS_OK}},
      '{ACT_FORK,        6'd21, 8'd85,  0, '{6'd0, 1'b0, 6'd0, STS_OK}}
    };
    in_idle_pct = 25;
    out_stall_pct = 65;
    foreach (directed[i]) begin
      row = directed[i];
      send_item(row.act, row.tid, row.prio);
      if (row.known && pending_results[$] != row.res) begin
        $error("directed row %0d: table value disagrees with prediction", i);
        errors++;
      end
    end
    drain();

    // A fresh-looking phase: saturate preempt depth, then fill the table.
    write_init(8'd255);
    repeat (260) send_item(ACT_PREEMPT_DIS, '0, '0);
    repeat (66) send_item(ACT_FORK, '0, '0);
    repeat (260) send_item(ACT_PREEMPT_EN, '0, '0);
    drain();

    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND / 3) begin
        in_idle_pct = 65;
        out_stall_pct = 25;
      end
      if (i == 2 * N_RAND / 3) begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
      if (i % 400 == 399) begin
        drain();
        p = (i % 800 == 399) ? 8'd0 : 8'($urandom_range(255));
        write_init(p);
      end
      send_item(pick_action(), 6'($urandom_range(63)), 8'($urandom_range(255)));
    end
    drain();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/cpts_pkg.sv
rtl/cpts_in_if.sv
rtl/cpts_out_if.sv
rtl/cpts_ctrl.sv
rtl/cpts_dpath.sv
rtl/counter_priority_task_scheduler_unit.sv
tb/sv/tb_chan_if.sv
tb/sv/tb.sv
